@@ rtl/core/tmfac_pkg.sv @@
package tmfac_pkg;

  // sample value field
  localparam int unsigned ValW = 12;
  localparam logic [ValW-1:0] ValMax = 12'hFFF;

  // calibration arithmetic widths
  localparam int unsigned CoefW = 32;
  localparam int unsigned ProdW = CoefW + ValW + 1;
  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned FracW = 16;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgXGainRx = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgXGainRy = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgXOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgYGainRx = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgYGainRy = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgYOffset = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxX    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMaxY    = 3'd7;

  // configuration reset values
  localparam logic signed [CoefW-1:0] RstXGainRx = 32'sd4415;
  localparam logic signed [CoefW-1:0] RstXGainRy = 32'sd43;
  localparam logic signed [CoefW-1:0] RstXOffset = -32'sd1088786;
  localparam logic signed [CoefW-1:0] RstYGainRx = 32'sd45;
  localparam logic signed [CoefW-1:0] RstYGainRy = -32'sd5920;
  localparam logic signed [CoefW-1:0] RstYOffset = 32'sd22956658;
  localparam logic [ValW-1:0] RstMaxX = 12'd239;
  localparam logic [ValW-1:0] RstMaxY = 12'd319;

  // result item fields apart from the calibrated point
  typedef struct packed {
    logic            status;
    logic            pressed;
    logic            valid_res;
    logic [ValW-1:0] raw_x;
    logic [ValW-1:0] raw_y;
  } tmfac_res_t;

endpackage

@@ rtl/core/tmfac_seq.sv @@
module tmfac_seq #(
  parameter int unsigned SAMPLES_PER_AXIS = 5,
  parameter int unsigned MIN_VALID_SAMPLES = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       acc_i,
  input  logic                       start_req_i,
  input  logic                       pen_down_i,
  input  logic [15:0]                sample_word_i,
  input  logic                       bus_error_i,
  output logic                       res_valid_o,
  output tmfac_pkg::tmfac_res_t      res_o
);

  localparam int unsigned Depth = SAMPLES_PER_AXIS - 1;
  localparam int unsigned IdxW = $clog2(SAMPLES_PER_AXIS);
  localparam int unsigned KeepW = $clog2(SAMPLES_PER_AXIS);
  localparam int unsigned PosW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ValW = tmfac_pkg::ValW;

  logic                active_q, active_d;
  logic                axis_y_q, axis_y_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [KeepW-1:0]    kept_q, kept_d;
  logic [ValW-1:0]     held_x_q, held_x_d;
  logic                held_ok_q, held_ok_d;
  logic [ValW-1:0]     sorted_q [Depth];
  logic [ValW-1:0]     sorted_d [Depth];
  logic                res_valid_q, res_valid_d;
  tmfac_pkg::tmfac_res_t res_q, res_d;

  logic [ValW-1:0]     val;
  logic                keep;
  logic [Depth:0]      gt;
  logic [ValW-1:0]     prev [Depth];
  logic [KeepW-1:0]    kept_new;
  logic [KeepW-1:0]    med_pos;
  logic [ValW-1:0]     median;
  logic                med_ok;
  logic                axis_done;

  assign val = sample_word_i[14:3];
  assign keep = (idx_q != '0) && (val != '0) && (val != tmfac_pkg::ValMax)
                && (int'(kept_q) < Depth);
  assign axis_done = (int'(idx_q) == SAMPLES_PER_AXIS - 1);

  // sorted insertion of the new value
  always_comb begin
    gt[0] = 1'b0;
    prev[0] = val;
    for (int j = 0; j < Depth; j++) begin
      gt[j+1] = (sorted_q[j] > val);
    end
    for (int j = 1; j < Depth; j++) begin
      prev[j] = sorted_q[j-1];
    end
    for (int j = 0; j < Depth; j++) begin
      sorted_d[j] = sorted_q[j];
      if (keep) begin
        if (j < int'(kept_q) && !gt[j+1]) begin
          sorted_d[j] = sorted_q[j];
        end else if (j <= int'(kept_q)) begin
          sorted_d[j] = gt[j] ? prev[j] : val;
        end
      end
    end
  end

  // lower median of the kept samples including this one
  always_comb begin
    kept_new = keep ? kept_q + 1'b1 : kept_q;
    med_pos = (kept_new - 1'b1) >> 1;
    med_ok = (kept_new != '0) && (int'(kept_new) >= MIN_VALID_SAMPLES);
    median = '0;
    for (int j = 0; j < Depth; j++) begin
      if (med_pos[PosW-1:0] == PosW'(j)) begin
        median = sorted_d[j];
      end
    end
    if (!med_ok) begin
      median = '0;
    end
  end

  // read sequencing
  always_comb begin
    active_d = active_q;
    axis_y_d = axis_y_q;
    idx_d = idx_q;
    kept_d = kept_q;
    held_x_d = held_x_q;
    held_ok_d = held_ok_q;
    res_valid_d = 1'b0;
    res_d = '0;
    if (acc_i) begin
      if (start_req_i) begin
        idx_d = '0;
        kept_d = '0;
        axis_y_d = 1'b0;
        held_x_d = '0;
        held_ok_d = 1'b0;
        active_d = pen_down_i;
        res_valid_d = !pen_down_i;
      end else if (active_q) begin
        if (bus_error_i) begin
          active_d = 1'b0;
          idx_d = '0;
          kept_d = '0;
          axis_y_d = 1'b0;
          res_valid_d = 1'b1;
          res_d.status = 1'b1;
        end else if (!axis_done) begin
          idx_d = idx_q + 1'b1;
          kept_d = kept_new;
        end else begin
          idx_d = '0;
          kept_d = '0;
          if (!axis_y_q) begin
            held_x_d = median;
            held_ok_d = med_ok;
            axis_y_d = 1'b1;
          end else begin
            active_d = 1'b0;
            axis_y_d = 1'b0;
            res_valid_d = 1'b1;
            res_d.pressed = 1'b1;
            if (held_ok_q && med_ok) begin
              res_d.valid_res = 1'b1;
              res_d.raw_x = held_x_q;
              res_d.raw_y = median;
            end
          end
        end
      end
    end
  end

  // control state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      axis_y_q <= 1'b0;
      idx_q <= '0;
      kept_q <= '0;
      held_x_q <= '0;
      held_ok_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q <= '0;
    end else if (en_i) begin
      active_q <= active_d;
      axis_y_q <= axis_y_d;
      idx_q <= idx_d;
      kept_q <= kept_d;
      held_x_q <= held_x_d;
      held_ok_q <= held_ok_d;
      res_valid_q <= res_valid_d;
      res_q <= res_d;
    end
  end

  // sort storage
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      sorted_q <= sorted_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

endmodule

@@ rtl/core/tmfac_calib.sv @@
module tmfac_calib (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [tmfac_pkg::CoefW-1:0]        gain_a_i,
  input  logic signed [tmfac_pkg::CoefW-1:0]        gain_b_i,
  input  logic signed [tmfac_pkg::CoefW-1:0]        offset_i,
  input  logic [tmfac_pkg::ValW-1:0]                max_i,
  input  logic [tmfac_pkg::ValW-1:0]                raw_a_i,
  input  logic [tmfac_pkg::ValW-1:0]                raw_b_i,
  input  logic                                      use_i,
  output logic [tmfac_pkg::ValW-1:0]                screen_o
);

  localparam int unsigned ValW = tmfac_pkg::ValW;
  localparam int unsigned ProdW = tmfac_pkg::ProdW;
  localparam int unsigned SumW = tmfac_pkg::SumW;
  localparam int unsigned FracW = tmfac_pkg::FracW;

  logic signed [ValW:0]    ra_s, rb_s;
  logic signed [ProdW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic                    use_q;
  logic signed [SumW-1:0]  sum, rnd, lim;
  logic [ValW-1:0]         scr_d, scr_q;

  // product stage
  assign ra_s = signed'({1'b0, raw_a_i});
  assign rb_s = signed'({1'b0, raw_b_i});
  assign pa_d = gain_a_i * ra_s;
  assign pb_d = gain_b_i * rb_s;

  // sum, clamp and round half up
  always_comb begin
    sum = SumW'(pa_q) + SumW'(pb_q) + SumW'(offset_i);
    lim = signed'({{(SumW-ValW-FracW){1'b0}}, max_i, {FracW{1'b0}}});
    rnd = sum + signed'(SumW'(1) <<< (FracW - 1));
    if (!use_q || sum <= 0) begin
      scr_d = '0;
    end else if (sum >= lim) begin
      scr_d = max_i;
    end else begin
      scr_d = rnd[FracW +: ValW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      use_q <= use_i;
      scr_q <= scr_d;
    end
  end

  assign screen_o = scr_q;

endmodule

@@ rtl/core/touch_median_filter_affine_calibrate_unit.sv @@
// Touch read sequencer with median filter and affine calibration.
// Input items (s_axis) carry a start request with the pen state, or one
// conversion word with a bus error flag. A read started with the pen down
// takes SAMPLES_PER_AXIS words for X and then as many for Y; the first word
// of each axis and words at 0 or full scale are dropped, the rest are kept
// sorted and the lower median is used. One result item (m_axis) follows the
// last Y word, a bus error, or a start with the pen up.
// Pipeline: the sequencer, product and sum/clamp registers load in turn, the
// sequencer register on the edge that accepts the item, and m_axis_tvalid
// is driven from the valid that travels with the sum/clamp register.
// Throughput: one item per cycle while the output is not stalled; the sorted
// insertion of a word fits in the cycle it is accepted and the calibration
// is pipelined behind it.
// Stall: all stages move together; s_axis_tready is low only while a result
// waits in the output register and m_axis_tready is low.
// Reset: no read is active, the pipeline is empty and the calibration
// registers take their default values. Registers are to be written through
// cfg_we_i / cfg_idx_i / cfg_data_i only while idle, unenforced by the block.
module touch_median_filter_affine_calibrate_unit #(
  parameter int unsigned SAMPLES_PER_AXIS = 5,
  parameter int unsigned MIN_VALID_SAMPLES = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_req [0], pen_down [1], sample_word [17:2], bus_error [18]
  input  logic [23:0]                         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status [0], pressed [1], valid_res [2], raw_x [14:3], raw_y [26:15],
  // cal_x [38:27], cal_y [50:39]
  output logic [55:0]                         m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tmfac_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tmfac_pkg::CoefW-1:0]         cfg_data_i
);

  localparam int unsigned ValW = tmfac_pkg::ValW;
  localparam int unsigned CoefW = tmfac_pkg::CoefW;

  logic signed [CoefW-1:0] xg_rx_q, xg_ry_q, x_off_q, yg_rx_q, yg_ry_q, y_off_q;
  logic [ValW-1:0]         max_x_q, max_y_q;

  logic                    en, acc;
  logic                    a_valid;
  tmfac_pkg::tmfac_res_t   res_a, res_b_q, res_c_q;
  logic                    b_valid_q, c_valid_q;
  logic [ValW-1:0]         scr_x, scr_y;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xg_rx_q <= tmfac_pkg::RstXGainRx;
      xg_ry_q <= tmfac_pkg::RstXGainRy;
      x_off_q <= tmfac_pkg::RstXOffset;
      yg_rx_q <= tmfac_pkg::RstYGainRx;
      yg_ry_q <= tmfac_pkg::RstYGainRy;
      y_off_q <= tmfac_pkg::RstYOffset;
      max_x_q <= tmfac_pkg::RstMaxX;
      max_y_q <= tmfac_pkg::RstMaxY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmfac_pkg::CfgXGainRx: xg_rx_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgXGainRy: xg_ry_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgXOffset: x_off_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgYGainRx: yg_rx_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgYGainRy: yg_ry_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgYOffset: y_off_q <= signed'(cfg_data_i);
        tmfac_pkg::CfgMaxX:    max_x_q <= cfg_data_i[ValW-1:0];
        tmfac_pkg::CfgMaxY:    max_y_q <= cfg_data_i[ValW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en = !c_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc = s_axis_tvalid && en;

  tmfac_seq #(
    .SAMPLES_PER_AXIS  (SAMPLES_PER_AXIS),
    .MIN_VALID_SAMPLES (MIN_VALID_SAMPLES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .acc_i         (acc),
    .start_req_i   (s_axis_tdata[0]),
    .pen_down_i    (s_axis_tdata[1]),
    .sample_word_i (s_axis_tdata[17:2]),
    .bus_error_i   (s_axis_tdata[18]),
    .res_valid_o   (a_valid),
    .res_o         (res_a)
  );

  tmfac_calib u_calib_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .gain_a_i (xg_rx_q),
    .gain_b_i (xg_ry_q),
    .offset_i (x_off_q),
    .max_i    (max_x_q),
    .raw_a_i  (res_a.raw_x),
    .raw_b_i  (res_a.raw_y),
    .use_i    (res_a.valid_res),
    .screen_o (scr_x)
  );

  tmfac_calib u_calib_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .gain_a_i (yg_rx_q),
    .gain_b_i (yg_ry_q),
    .offset_i (y_off_q),
    .max_i    (max_y_q),
    .raw_a_i  (res_a.raw_x),
    .raw_b_i  (res_a.raw_y),
    .use_i    (res_a.valid_res),
    .screen_o (scr_y)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid;
      c_valid_q <= b_valid_q;
    end
  end

  // result fields aligned with the calibration stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_b_q <= res_a;
      res_c_q <= res_b_q;
    end
  end

  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata = {5'b0, scr_y, scr_x, res_c_q.raw_y, res_c_q.raw_x,
                         res_c_q.valid_res, res_c_q.pressed, res_c_q.status};

`ifndef SYNTH
  // an aborted read reports neither a press nor a point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_c_q.status |-> !res_c_q.pressed && !res_c_q.valid_res)
    else $error("aborted result carries press or valid flag");

  // a result without a valid point has all numeric fields at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_c_q.valid_res |-> res_c_q.raw_x == '0 && res_c_q.raw_y == '0
      && scr_x == '0 && scr_y == '0)
    else $error("invalid result has nonzero fields");

  // calibrated point stays inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_c_q.valid_res |-> scr_x <= max_x_q && scr_y <= max_y_q)
    else $error("screen point beyond clamp limit");

  // a new output item comes from the product stage in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(b_valid_q))
    else $error("output item without a product stage item");
`endif

endmodule

@@ tb/touch_point_checker.sv @@
`timescale 1ns / 1ps

module touch_point_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  // start_req [0], pen_down [1], sample_word [17:2], bus_error [18]
  input  logic [23:0]                   in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  // status [0], pressed [1], valid_res [2], raw_x [14:3], raw_y [26:15],
  // cal_x [38:27], cal_y [50:39]
  input  logic [55:0]                   out_data_i,
  input  logic                          cfg_we_i,
  input  logic [tmfac_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmfac_pkg::CoefW-1:0]   cfg_data_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            checked_o
);

  localparam int unsigned ValW = tmfac_pkg::ValW;
  localparam int unsigned CoefW = tmfac_pkg::CoefW;
  localparam logic [ValW-1:0] ValMax = tmfac_pkg::ValMax;
  localparam int SamplesPerAxis = 5;
  localparam int MinValid = 3;
  localparam int RankDepth = SamplesPerAxis - 1;

  typedef struct packed {
    logic            status;
    logic            pressed;
    logic            valid_res;
    logic [ValW-1:0] raw_x;
    logic [ValW-1:0] raw_y;
    logic [ValW-1:0] cal_x;
    logic [ValW-1:0] cal_y;
  } touch_item_t;

  // calibration copy
  logic signed [CoefW-1:0] sx_gain_rx, sx_gain_ry, sx_off;
  logic signed [CoefW-1:0] sy_gain_rx, sy_gain_ry, sy_off;
  logic [ValW-1:0]         lim_x, lim_y;

  // read sequencer copy
  logic            busy;
  logic            on_y;
  int              idx;
  int              kept;
  logic [ValW-1:0] ranked [RankDepth];
  logic [ValW-1:0] held_x;
  logic            held_x_ok;

  touch_item_t expected_points [$];

  // q15.16 affine map, rounded half up and clamped to 0..lim
  function automatic logic [ValW-1:0] screen_coord(
    logic signed [CoefW-1:0] ga, logic signed [CoefW-1:0] gb,
    logic signed [CoefW-1:0] off, logic [ValW-1:0] rx, logic [ValW-1:0] ry,
    logic [ValW-1:0] lim);
    longint acc;
    acc = longint'(ga) * longint'(rx) + longint'(gb) * longint'(ry) + longint'(off);
    if (acc <= 0) return '0;
    if (acc >= longint'(lim) * 65536) return lim;
    return ValW'((acc + 32768) >> 16);
  endfunction

  task automatic insert_sorted(input logic [ValW-1:0] v);
    int pos;
    if (kept >= RankDepth) return;
    pos = kept;
    while (pos > 0 && ranked[pos-1] > v) begin
      ranked[pos] = ranked[pos-1];
      pos--;
    end
    ranked[pos] = v;
    kept++;
  endtask

  task automatic lower_median(output logic [ValW-1:0] med, output logic ok);
    ok = (kept >= MinValid) && (kept <= RankDepth);
    med = ok ? ranked[(kept-1)/2] : '0;
  endtask

  // advance the sequencer by one accepted item
  task automatic take_item(input logic [23:0] d);
    logic            pen, berr;
    logic [ValW-1:0] v, ry_med;
    logic            y_ok;
    touch_item_t     p;
    pen = d[1];
    v = d[16:5];
    berr = d[18];
    p = '0;
    if (d[0]) begin
      idx = 0;
      kept = 0;
      on_y = 1'b0;
      held_x = '0;
      held_x_ok = 1'b0;
      busy = pen;
      if (!pen) expected_points.push_back(p);
    end else if (busy) begin
      if (berr) begin
        busy = 1'b0;
        idx = 0;
        kept = 0;
        on_y = 1'b0;
        p.status = 1'b1;
        expected_points.push_back(p);
      end else begin
        if (idx != 0 && v != '0 && v != ValMax) insert_sorted(v);
        idx++;
        if (idx == SamplesPerAxis) begin
          idx = 0;
          if (!on_y) begin
            lower_median(held_x, held_x_ok);
            kept = 0;
            on_y = 1'b1;
          end else begin
            lower_median(ry_med, y_ok);
            kept = 0;
            on_y = 1'b0;
            busy = 1'b0;
            p.pressed = 1'b1;
            if (held_x_ok && y_ok) begin
              p.valid_res = 1'b1;
              p.raw_x = held_x;
              p.raw_y = ry_med;
              p.cal_x = screen_coord(sx_gain_rx, sx_gain_ry, sx_off, held_x, ry_med, lim_x);
              p.cal_y = screen_coord(sy_gain_rx, sy_gain_ry, sy_off, held_x, ry_med, lim_y);
            end
            expected_points.push_back(p);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  // compare one result item with the oldest expected point
  task automatic check_point(input logic [55:0] d);
    touch_item_t want;
    if (expected_points.size() == 0) begin
      $display("%0t ns: result item 0x%h with no expected point", $time, d);
      mismatches_o++;
      return;
    end
    want = expected_points.pop_front();
    checked_o++;
    check_field("status", ValW'(want.status), ValW'(d[0]));
    check_field("pressed", ValW'(want.pressed), ValW'(d[1]));
    check_field("valid_res", ValW'(want.valid_res), ValW'(d[2]));
    check_field("raw_x", want.raw_x, d[14:3]);
    check_field("raw_y", want.raw_y, d[26:15]);
    check_field("cal_x", want.cal_x, d[38:27]);
    check_field("cal_y", want.cal_y, d[50:39]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_gain_rx = tmfac_pkg::RstXGainRx;
      sx_gain_ry = tmfac_pkg::RstXGainRy;
      sx_off = tmfac_pkg::RstXOffset;
      sy_gain_rx = tmfac_pkg::RstYGainRx;
      sy_gain_ry = tmfac_pkg::RstYGainRy;
      sy_off = tmfac_pkg::RstYOffset;
      lim_x = tmfac_pkg::RstMaxX;
      lim_y = tmfac_pkg::RstMaxY;
      busy = 1'b0;
      on_y = 1'b0;
      idx = 0;
      kept = 0;
      held_x = '0;
      held_x_ok = 1'b0;
      expected_points.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tmfac_pkg::CfgXGainRx: sx_gain_rx = cfg_data_i;
          tmfac_pkg::CfgXGainRy: sx_gain_ry = cfg_data_i;
          tmfac_pkg::CfgXOffset: sx_off = cfg_data_i;
          tmfac_pkg::CfgYGainRx: sy_gain_rx = cfg_data_i;
          tmfac_pkg::CfgYGainRy: sy_gain_ry = cfg_data_i;
          tmfac_pkg::CfgYOffset: sy_off = cfg_data_i;
          tmfac_pkg::CfgMaxX:    lim_x = cfg_data_i[ValW-1:0];
          tmfac_pkg::CfgMaxY:    lim_y = cfg_data_i[ValW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_point(out_data_i);
      if (in_valid_i && in_ready_i) take_item(in_data_i);
    end
    pending_o = expected_points.size();
  end

endmodule

@@ tb/tb_touch_median_filter_affine_calibrate_unit.sv @@
`timescale 1ns / 1ps

module tb_touch_median_filter_affine_calibrate_unit;

  localparam int PhaseCount = 7;
  localparam int PhaseItems = 276;
  localparam int HoldOffCycles = 300;
  localparam int IdleLimit = 3000;
  localparam int SettleCycles = 8;
  localparam int unsigned ValW = tmfac_pkg::ValW;
  localparam int unsigned CoefW = tmfac_pkg::CoefW;
  localparam int unsigned CfgIdxW = tmfac_pkg::CfgIdxW;
  localparam logic [ValW-1:0] ValMax = tmfac_pkg::ValMax;

  typedef struct {
    logic [31:0] xrx, xry, xoff, yrx, yry, yoff, maxx, maxy;
  } cal_set_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [23:0]        s_data = '0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [55:0]        m_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = tmfac_pkg::CfgXGainRx;
  logic [CoefW-1:0]   cfg_data = '0;

  int mismatches, pending, checked;
  int sent_items = 0;
  int idle_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  touch_median_filter_affine_calibrate_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  touch_point_checker point_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles with no item moving", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stalls in spans of random style, plus one long hold-off
  initial begin : receiver
    int style, span, cyc;
    bit held;
    style = 0;
    span = 0;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        m_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        held = 1'b1;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(32, 256);
      end
      span--;
      cyc++;
      case (style)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= ($urandom_range(0, 3) == 0);
        default: m_ready <= (cyc % 5) < 3;
      endcase
    end
  end

  function automatic logic [23:0] pack_item(logic start, logic pen, logic [15:0] word,
                                            logic berr);
    return {5'd0, berr, word, pen, start};
  endfunction

  // offer one item in bursts with random gaps; returns at the falling edge
  // after acceptance
  task automatic put_item(input logic [23:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= d;
    do @(posedge clk); while (!s_ready);
    sent_items++;
    @(negedge clk);
  endtask

  // start item: word and bus error are don't-care here
  task automatic put_start(input logic pen);
    logic [15:0] w;
    w = 16'($urandom);
    put_item(pack_item(1'b1, pen, w, 1'($urandom_range(0, 1))));
  endtask

  task automatic put_sample(input logic [ValW-1:0] v, input logic berr);
    logic [15:0] w;
    w = 16'($urandom);
    w[14:3] = v;
    put_item(pack_item(1'b0, 1'($urandom_range(0, 1)), w, berr));
  endtask

  function automatic logic [ValW-1:0] pick_value(logic [ValW-1:0] centre);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return ValMax;
    if (r < 28) return 12'd1;
    if (r < 32) return ValMax - 12'd1;
    if (r < 60) return ValW'($urandom);
    return centre ^ ValW'($urandom_range(0, 15));
  endfunction

  // one touch read, sometimes pen up, cut short by a restart, or broken
  task automatic run_read();
    int err_at, cut;
    logic [ValW-1:0] centre;
    centre = ValW'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      put_start(1'b0);
      return;
    end
    if ($urandom_range(0, 14) == 0) begin
      put_start(1'b1);
      cut = $urandom_range(0, 8);
      repeat (cut) put_sample(pick_value(centre), 1'b0);
    end
    err_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : -1;
    put_start(1'b1);
    for (int i = 0; i < 10; i++) begin
      if (i == 5) centre = ValW'($urandom);
      put_sample(pick_value(centre), i == err_at);
      if (i == err_at) return;
    end
  endtask

  // stop offering, let every expected result drain, then let the pipe empty
  task automatic settle();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic poke(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic write_cal(input cal_set_t c);
    poke(tmfac_pkg::CfgXGainRx, c.xrx);
    poke(tmfac_pkg::CfgXGainRy, c.xry);
    poke(tmfac_pkg::CfgXOffset, c.xoff);
    poke(tmfac_pkg::CfgYGainRx, c.yrx);
    poke(tmfac_pkg::CfgYGainRy, c.yry);
    poke(tmfac_pkg::CfgYOffset, c.yoff);
    poke(tmfac_pkg::CfgMaxX, c.maxx);
    poke(tmfac_pkg::CfgMaxY, c.maxy);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    cal_set_t cs;
    int base;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pen up, restart mid read, invalid Y axis, idle item, bus error
    put_start(1'b0);
    put_start(1'b1);
    put_sample(12'd777, 1'b0);
    put_start(1'b1);
    put_sample(12'd50, 1'b0);
    put_sample(12'd4094, 1'b0);
    put_sample(12'd1, 1'b0);
    put_sample(12'd2048, 1'b0);
    put_sample(12'd3, 1'b0);
    put_sample(ValMax, 1'b0);
    put_sample(12'd0, 1'b0);
    put_sample(12'd1000, 1'b0);
    put_sample(12'd1000, 1'b0);
    put_sample(ValMax, 1'b0);
    put_item(pack_item(1'b0, 1'b1, 16'hFFFF, 1'b1));
    idle_items++;
    put_start(1'b1);
    put_sample(12'd1234, 1'b0);
    put_sample(12'd2345, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          // plausible panel map
          1: cs = '{$urandom_range(0, 2**18) - 2**17, $urandom_range(0, 2**14) - 2**13,
                    $urandom_range(0, 2**25) - 2**24, $urandom_range(0, 2**14) - 2**13,
                    $urandom_range(0, 2**18) - 2**17, $urandom_range(0, 2**25) - 2**24,
                    {20'($urandom), 12'($urandom)}, {20'($urandom), 12'($urandom)}};
          // largest positive coefficients
          2: cs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F000};
          // most negative coefficients
          3: cs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'hFFFF_F000, 32'h0000_0FFF};
          // exact halves to hit rounding
          4: cs = '{32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000,
                    32'h0000_0FFF, 32'h0000_0FFF};
          5: cs = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom};
          default: cs = '{tmfac_pkg::RstXGainRx, tmfac_pkg::RstXGainRy,
                          tmfac_pkg::RstXOffset, tmfac_pkg::RstYGainRx,
                          tmfac_pkg::RstYGainRy, tmfac_pkg::RstYOffset,
                          32'(tmfac_pkg::RstMaxX), 32'(tmfac_pkg::RstMaxY)};
        endcase
        write_cal(cs);
      end
      base = sent_items - idle_items;
      while (sent_items - idle_items < (ph + 1) * PhaseItems) begin
        if (ph == 1 && sent_items - idle_items > base + 60) hold_off_req = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          put_item(pack_item(1'b0, 1'($urandom_range(0, 1)), 16'($urandom),
                             1'($urandom_range(0, 1))));
          idle_items++;
        end
        run_read();
      end
    end

    settle();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d items (%0d idle) over %0d calibration settings",
             sent_items - idle_items, idle_items, PhaseCount);
    $display("%0d result items checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
